// ===== src/wmc_pkg.sv =====
// Shared types and constants of the Weibull mixture CDF and gradient pipeline.
// Holds field widths, fixed-point constants, register indexes and the exp(-1) constant.
// No dependencies.
package wmc_pkg;

  localparam int POS_W        = 16;
  localparam int AMP_W        = 18;
  localparam int SCALE_W      = 24;
  localparam int U_W          = 34;
  localparam int E_W          = 17;
  localparam int GRAD_W       = 35;
  localparam int TOTAL_W      = 20;
  localparam int SERIES_TERMS = 16;
  localparam int POW_STAGES   = 11;

  localparam logic [U_W-1:0]    U_LIMIT   = 34'h1_8000_0000;
  localparam logic [GRAD_W-1:0] GRAD_SAT  = 35'h4_0000_0000;
  localparam logic [E_W-1:0]    ONE_Q16   = 17'h1_0000;
  localparam logic [31:0]       ONE_Q31   = 32'h8000_0000;
  localparam logic [32:0]       ROUND_Q15 = 33'h0_0000_4000;

  typedef enum logic [2:0] {
    REG_AMP_ONE     = 3'd0,
    REG_SCALE_ONE   = 3'd1,
    REG_AMP_TWO     = 3'd2,
    REG_SCALE_TWO   = 3'd3,
    REG_AMP_THREE   = 3'd4,
    REG_SCALE_THREE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [AMP_W-1:0]   amp;
    logic [SCALE_W-1:0] scale;
  } curve_cfg_t;

  function automatic logic [31:0] exp_series_const(input logic [31:0] f31);
    logic [63:0] term;
    longint      acc;
    term = 64'(ONE_Q31);
    acc  = longint'(ONE_Q31);
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      term = ((term * 64'(f31)) >> 31) / 64'(n);
      if ((n % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(ONE_Q31)) begin
      acc = longint'(ONE_Q31);
    end
    return 32'(acc);
  endfunction

  localparam logic [31:0] EXP_NEG_ONE = exp_series_const(ONE_Q31);

endpackage

// ===== src/wmc_div.sv =====
// Pipelined restoring divider, STEP quotient bits per stage, divisor held stable.
// Carries a sideband word alongside each request.
// Depends on wmc_pkg.
module wmc_div import wmc_pkg::*; #(
  parameter int NUM_W = 33,
  parameter int STEP  = 3,
  parameter int SB_W  = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [SCALE_W-1:0] in_rem,
  input  logic [NUM_W-1:0]   in_num,
  input  logic [SB_W-1:0]    in_sb,
  input  logic [SCALE_W-1:0] divisor,
  output logic               out_valid,
  output logic [NUM_W-1:0]   out_quo,
  output logic [SB_W-1:0]    out_sb
);

  localparam int STAGES = NUM_W / STEP;

  logic [STAGES-1:0]  v_r;
  logic [SCALE_W-1:0] rem_r [STAGES];
  logic [NUM_W-1:0]   qn_r  [STAGES];
  logic [SB_W-1:0]    sb_r  [STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[STAGES-2:0], in_valid};
    end
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [SCALE_W-1:0] src_rem;
    logic [NUM_W-1:0]   src_qn;
    logic [SB_W-1:0]    src_sb;
    logic [SCALE_W-1:0] rem_c;
    logic [NUM_W-1:0]   qn_c;
    logic [SCALE_W:0]   trial;

    if (s == 0) begin : g_first
      assign src_rem = in_rem;
      assign src_qn  = in_num;
      assign src_sb  = in_sb;
    end else begin : g_next
      assign src_rem = rem_r[s-1];
      assign src_qn  = qn_r[s-1];
      assign src_sb  = sb_r[s-1];
    end

    always_comb begin
      rem_c = src_rem;
      qn_c  = src_qn;
      trial = '0;
      for (int b = 0; b < STEP; b++) begin
        trial = {rem_c, qn_c[NUM_W-1]};
        qn_c  = {qn_c[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          trial   = trial - {1'b0, divisor};
          qn_c[0] = 1'b1;
        end
        rem_c = trial[SCALE_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= rem_c;
        qn_r[s]  <= qn_c;
        sb_r[s]  <= src_sb;
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_quo   = qn_r[STAGES-1];
  assign out_sb    = sb_r[STAGES-1];

endmodule

// ===== src/wmc_exp.sv =====
// exp(-u) pipeline: Taylor series of the fraction, then repeated exp(-1) products.
// Result in Q1.16 with rounding; forced to zero on request.
// Depends on wmc_pkg.
module wmc_exp import wmc_pkg::*; #(
  parameter int SB_W = 34
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [30:0]     in_f,
  input  logic [3:0]      in_whole,
  input  logic            in_zero,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [E_W-1:0]  out_e,
  output logic [SB_W-1:0] out_sb
);

  localparam int SER = 2 * SERIES_TERMS;
  localparam int STG = SER + POW_STAGES + 2;

  logic [STG-1:0]     v_r;
  logic [30:0]        f_r     [STG];
  logic [3:0]         whole_r [STG];
  logic               zero_r  [STG];
  logic [SB_W-1:0]    sb_r    [STG];

  logic [30:0]        p_r    [1:SERIES_TERMS];
  logic [31:0]        term_r [1:SERIES_TERMS];
  logic signed [33:0] sum_r  [0:SER-1];
  logic [31:0]        pw_r   [0:POW_STAGES];
  logic [E_W-1:0]     e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[STG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r[0]     <= in_f;
      whole_r[0] <= in_whole;
      zero_r[0]  <= in_zero;
      sb_r[0]    <= in_sb;
      for (int k = 1; k < STG; k++) begin
        f_r[k]     <= f_r[k-1];
        whole_r[k] <= whole_r[k-1];
        zero_r[k]  <= zero_r[k-1];
        sb_r[k]    <= sb_r[k-1];
      end
    end
  end

  for (genvar n = 1; n <= SERIES_TERMS; n++) begin : g_term
    localparam logic [35:0] MAGIC =
      36'(((64'd1 << 35) + 64'(n) - 64'd1) / 64'(n));
    logic [31:0]        t_src;
    logic [30:0]        f_src;
    logic signed [33:0] s_src;
    logic [62:0]        a_prod;
    logic [66:0]        b_prod;
    logic signed [33:0] sum_nxt;

    if (n == 1) begin : g_first
      assign t_src = ONE_Q31;
      assign f_src = in_f;
      assign s_src = '0;
    end else begin : g_next
      assign t_src = term_r[n-1];
      assign f_src = f_r[2*n-3];
      assign s_src = sum_r[2*n-3];
    end

    assign a_prod = 63'(t_src) * 63'(f_src);
    assign b_prod = 67'(p_r[n]) * 67'(MAGIC);

    always_comb begin
      if ((n % 2) == 0) begin
        sum_nxt = s_src - $signed({2'b00, t_src});
      end else begin
        sum_nxt = s_src + $signed({2'b00, t_src});
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        p_r[n]         <= a_prod[61:31];
        sum_r[2*n-2]   <= sum_nxt;
        term_r[n]      <= {1'b0, b_prod[65:35]};
        sum_r[2*n-1]   <= sum_r[2*n-2];
      end
    end
  end

  logic signed [33:0] sum_fin;
  logic [31:0]        v_clamp;

  always_comb begin
    sum_fin = sum_r[SER-1] + $signed({2'b00, term_r[SERIES_TERMS]});
    if (sum_fin < 0) begin
      v_clamp = '0;
    end else if (sum_fin > $signed({2'b00, ONE_Q31})) begin
      v_clamp = ONE_Q31;
    end else begin
      v_clamp = sum_fin[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pw_r[0] <= v_clamp;
    end
  end

  for (genvar j = 0; j < POW_STAGES; j++) begin : g_pow
    logic [63:0] m_prod;
    assign m_prod = 64'(pw_r[j]) * 64'(EXP_NEG_ONE);

    always_ff @(posedge clk) begin
      if (adv) begin
        if (4'(j) < whole_r[SER+j]) begin
          pw_r[j+1] <= m_prod[62:31];
        end else begin
          pw_r[j+1] <= pw_r[j];
        end
      end
    end
  end

  logic [32:0] rnd;
  logic [17:0] e_full;
  logic [E_W-1:0] e_nxt;

  always_comb begin
    rnd    = {1'b0, pw_r[POW_STAGES]} + ROUND_Q15;
    e_full = rnd[32:15];
    if (zero_r[STG-2]) begin
      e_nxt = '0;
    end else if (e_full > {1'b0, ONE_Q16}) begin
      e_nxt = ONE_Q16;
    end else begin
      e_nxt = e_full[E_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r <= e_nxt;
    end
  end

  assign out_valid = v_r[STG-1];
  assign out_e     = e_r;
  assign out_sb    = sb_r[STG-1];

endmodule

// ===== src/wmc_curve.sv =====
// One Weibull curve: ratio divider, power (a square when SHAPE_TWO), exp, gradient product and scale divider.
// Emits 1-e in Q1.16 and the saturated scale gradient in Q10.24.
// Depends on wmc_pkg, wmc_div and wmc_exp.
module wmc_curve import wmc_pkg::*; #(
  parameter bit SHAPE_TWO = 1'b1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [POS_W-1:0]  in_pos,
  input  curve_cfg_t        cfg,
  output logic              out_valid,
  output logic [E_W-1:0]    out_grad_amp,
  output logic [GRAD_W-1:0] out_grad_scale
);

  logic [SCALE_W-1:0] pos_rem;
  logic               ovf;
  logic               d1_valid;
  logic [32:0]        d1_quo;
  logic               d1_ovf;

  assign pos_rem = {5'b0, in_pos, 3'b0};
  assign ovf     = pos_rem >= cfg.scale;

  wmc_div #(.NUM_W(33), .STEP(3), .SB_W(1)) u_div_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_rem    (pos_rem),
    .in_num    ('0),
    .in_sb     (ovf),
    .divisor   (cfg.scale),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_sb    (d1_ovf)
  );

  logic [61:0]    sq;
  logic [U_W-1:0] u_nxt;
  logic           sat_nxt;
  logic           sq_v_r;
  logic [U_W-1:0] u_r;
  logic           sat_r;

  assign sq = 62'(d1_quo[30:0]) * 62'(d1_quo[30:0]);

  always_comb begin
    if (SHAPE_TWO) begin
      u_nxt   = sq[61:28];
      sat_nxt = d1_ovf | (|d1_quo[32:31]);
    end else begin
      u_nxt   = {1'b0, d1_quo};
      sat_nxt = d1_ovf;
    end
  end

  logic           pr_v_r;
  logic [U_W-1:0] pr_u_r;
  logic           pr_zero_r;
  logic [3:0]     pr_whole_r;
  logic [30:0]    pr_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
      pr_v_r <= 1'b0;
    end else if (adv) begin
      sq_v_r <= d1_valid;
      pr_v_r <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r        <= u_nxt;
      sat_r      <= sat_nxt;
      pr_u_r     <= u_r;
      pr_zero_r  <= sat_r | (u_r >= U_LIMIT) | (u_r[33:28] >= 6'(POW_STAGES + 1));
      pr_whole_r <= u_r[31:28];
      pr_f_r     <= {u_r[27:0], 3'b0};
    end
  end

  logic           ex_valid;
  logic [E_W-1:0] ex_e;
  logic [U_W-1:0] ex_u;

  wmc_exp #(.SB_W(U_W)) u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (pr_v_r),
    .in_f      (pr_f_r),
    .in_whole  (pr_whole_r),
    .in_zero   (pr_zero_r),
    .in_sb     (pr_u_r),
    .out_valid (ex_valid),
    .out_e     (ex_e),
    .out_sb    (ex_u)
  );

  logic [50:0]    wprod;
  logic           w_v_r;
  logic [32:0]    w_r;
  logic [E_W-1:0] w_e_r;
  logic [50:0]    nprod;
  logic [39:0]    np_nxt;
  logic           n_v_r;
  logic [39:0]    np_r;
  logic [E_W-1:0] n_e_r;

  assign wprod = 51'(ex_u) * 51'(ex_e);
  assign nprod = 51'(cfg.amp) * 51'(w_r);

  always_comb begin
    if (SHAPE_TWO) begin
      np_nxt = nprod[50:11];
    end else begin
      np_nxt = {1'b0, nprod[50:12]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_v_r <= 1'b0;
      n_v_r <= 1'b0;
    end else if (adv) begin
      w_v_r <= ex_valid;
      n_v_r <= w_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r   <= wprod[48:16];
      w_e_r <= ex_e;
      np_r  <= np_nxt;
      n_e_r <= w_e_r;
    end
  end

  logic [SCALE_W-1:0] g_rem;
  logic               gov;
  logic               q_valid;
  logic [GRAD_W-1:0]  quo;
  logic [E_W:0]       q_sb;

  assign g_rem = {19'b0, np_r[39:35]};
  assign gov   = g_rem >= cfg.scale;

  wmc_div #(.NUM_W(GRAD_W), .STEP(5), .SB_W(E_W + 1)) u_div_grad (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (n_v_r),
    .in_rem    (g_rem),
    .in_num    (np_r[34:0]),
    .in_sb     ({n_e_r, gov}),
    .divisor   (cfg.scale),
    .out_valid (q_valid),
    .out_quo   (quo),
    .out_sb    (q_sb)
  );

  logic [GRAD_W-1:0] mag;
  logic              out_valid_r;
  logic [E_W-1:0]    ga_r;
  logic [GRAD_W-1:0] gs_r;

  always_comb begin
    if (cfg.scale == '0) begin
      mag = '0;
    end else if (q_sb[0] || (quo[34] && (|quo[33:0]))) begin
      mag = GRAD_SAT;
    end else begin
      mag = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ga_r <= ONE_Q16 - q_sb[E_W:1];
      gs_r <= '0 - mag;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_grad_amp   = ga_r;
  assign out_grad_scale = gs_r;

endmodule

// ===== src/weibull_mixture_cdf_gradient_top.sv =====
// Throughput: one request per cycle unless out_tready stalls the pipeline; set by the fully pipelined dividers,
// series terms and exp(-1) products, all stages advancing together.
// Reset: valid bits clear, amplitudes load 1.0 (Q2.16) and scales 1.0 (Q16.8).
// Depends on wmc_pkg, wmc_curve.
module weibull_mixture_cdf_gradient_top import wmc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // position[15:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [175:0] out_tdata,  // total, grad_amp_one, grad_scale_one, grad_amp_two,
                                   // grad_scale_two, grad_amp_three, grad_scale_three
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  curve_cfg_t cfg_one_r, cfg_two_r, cfg_three_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_one_r   <= '{amp: 18'd65536, scale: 24'd256};
      cfg_two_r   <= '{amp: 18'd65536, scale: 24'd256};
      cfg_three_r <= '{amp: 18'd65536, scale: 24'd256};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AMP_ONE:     cfg_one_r.amp     <= cfg_data[AMP_W-1:0];
        REG_SCALE_ONE:   cfg_one_r.scale   <= cfg_data;
        REG_AMP_TWO:     cfg_two_r.amp     <= cfg_data[AMP_W-1:0];
        REG_SCALE_TWO:   cfg_two_r.scale   <= cfg_data;
        REG_AMP_THREE:   cfg_three_r.amp   <= cfg_data[AMP_W-1:0];
        REG_SCALE_THREE: cfg_three_r.scale <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic adv;
  logic in_req;
  logic out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign in_req    = in_tvalid && in_tready;

  logic              c_valid;
  logic [E_W-1:0]    ga1, ga2, ga3;
  logic [GRAD_W-1:0] gs1, gs2, gs3;

  wmc_curve #(.SHAPE_TWO(1'b1)) u_curve_one (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_req),
    .in_pos         (in_tdata),
    .cfg            (cfg_one_r),
    .out_valid      (c_valid),
    .out_grad_amp   (ga1),
    .out_grad_scale (gs1)
  );

  wmc_curve #(.SHAPE_TWO(1'b1)) u_curve_two (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_req),
    .in_pos         (in_tdata),
    .cfg            (cfg_two_r),
    .out_valid      (),
    .out_grad_amp   (ga2),
    .out_grad_scale (gs2)
  );

  wmc_curve #(.SHAPE_TWO(1'b0)) u_curve_three (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .in_valid       (in_req),
    .in_pos         (in_tdata),
    .cfg            (cfg_three_r),
    .out_valid      (),
    .out_grad_amp   (ga3),
    .out_grad_scale (gs3)
  );

  logic              pm_v_r;
  logic [34:0]       pm1_r, pm2_r, pm3_r;
  logic [E_W-1:0]    pga1_r, pga2_r, pga3_r;
  logic [GRAD_W-1:0] pgs1_r, pgs2_r, pgs3_r;
  logic [36:0]       sum;
  logic [175:0]      out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      pm_v_r      <= c_valid;
      out_valid_r <= pm_v_r;
    end
  end

  assign sum = {2'b0, pm1_r} + {2'b0, pm2_r} + {2'b0, pm3_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      pm1_r      <= 35'(cfg_one_r.amp) * 35'(ga1);
      pm2_r      <= 35'(cfg_two_r.amp) * 35'(ga2);
      pm3_r      <= 35'(cfg_three_r.amp) * 35'(ga3);
      pga1_r     <= ga1;
      pga2_r     <= ga2;
      pga3_r     <= ga3;
      pgs1_r     <= gs1;
      pgs2_r     <= gs2;
      pgs3_r     <= gs3;
      out_data_r <= {pgs3_r, pga3_r, pgs2_r, pga2_r, pgs1_r, pga1_r, sum[35:16]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
